>>> design/rau_pkg.sv
`default_nettype none
package rau_pkg;

   // operand width used from each 32-bit field
   localparam int WIDTH = 32;
   // exact magnitude width of products and sums
   localparam int MAG_W = 2 * WIDTH;
   localparam int CNT_W = $clog2(MAG_W);

   localparam logic [MAG_W-1:0] POS_LIMIT = {{(MAG_W-WIDTH+1){1'b0}}, {(WIDTH-1){1'b1}}};
   localparam logic [MAG_W-1:0] NEG_LIMIT = POS_LIMIT + MAG_W'(1);

   // opcodes
   localparam logic [2:0] OP_ADD = 3'd0;
   localparam logic [2:0] OP_SUB = 3'd1;
   localparam logic [2:0] OP_MUL = 3'd2;
   localparam logic [2:0] OP_DIV = 3'd3;

   // status codes
   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_ZERO_DEN = 2'd1;
   localparam logic [1:0] ST_OVERFLOW = 2'd2;

   typedef enum logic [3:0] {
      S_IDLE, S_MUL0, S_MUL1, S_MUL2, S_SUM, S_RED, S_CHECK, S_EMIT
   } rau_state_type;

   typedef enum logic [2:0] {
      U_IDLE, U_GCD, U_DIVN, U_DIVD, U_DONE
   } rau_unit_state_type;

   typedef struct packed {
      logic             start;
      logic [MAG_W-1:0] nmag;
      logic [MAG_W-1:0] dmag;
   } rau_cmd_type;

   typedef struct packed {
      logic             done;
      logic [MAG_W-1:0] nred;
      logic [MAG_W-1:0] dred;
   } rau_resp_type;

endpackage
`default_nettype wire

>>> design/rau_reduce.sv
`default_nettype none
// Reduce a fraction: binary gcd, then two restoring divisions by the gcd.
module rau_reduce (
   input  wire                   clock,
   input  wire                   reset,
   input  wire rau_pkg::rau_cmd_type cmd,
   output rau_pkg::rau_resp_type resp
);
   import rau_pkg::*;

   rau_unit_state_type state_ff, state_in;
   logic [MAG_W-1:0] u_ff, u_in, v_ff, v_in;
   logic [CNT_W-1:0] k_ff, k_in, cnt_ff, cnt_in;
   logic [MAG_W-1:0] d_ff, d_in, g_ff, g_in;
   logic [MAG_W-1:0] rem_ff, rem_in, quo_ff, quo_in, nred_ff, nred_in;
   logic [MAG_W:0]   trial;
   logic             take;
   logic [MAG_W-1:0] rem_next, quo_next;
   logic             cnt_last;

   // one restoring division step
   assign trial    = {rem_ff, quo_ff[MAG_W-1]};
   assign take     = trial >= {1'b0, g_ff};
   assign rem_next = take ? MAG_W'(trial - {1'b0, g_ff}) : trial[MAG_W-1:0];
   assign quo_next = {quo_ff[MAG_W-2:0], take};
   assign cnt_last = &cnt_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         U_IDLE:  if (cmd.start) state_in = U_GCD;
         U_GCD:   if (u_ff == '0) state_in = U_DIVN;
         U_DIVN:  if (cnt_last) state_in = U_DIVD;
         U_DIVD:  if (cnt_last) state_in = U_DONE;
         U_DONE:  state_in = U_IDLE;
         default: state_in = U_IDLE;
      endcase
   end

   // datapath
   always_comb begin
      u_in = u_ff; v_in = v_ff; k_in = k_ff; cnt_in = cnt_ff;
      d_in = d_ff; g_in = g_ff; rem_in = rem_ff; quo_in = quo_ff; nred_in = nred_ff;
      unique case (state_ff)
         U_IDLE: begin
            if (cmd.start) begin
               u_in = cmd.nmag; v_in = cmd.dmag; k_in = '0;
               d_in = cmd.dmag; quo_in = cmd.nmag;
            end
         end
         U_GCD: begin
            priority if (u_ff == '0) begin
               g_in = v_ff << k_ff; rem_in = '0; cnt_in = '0;
            end else if (!u_ff[0] && !v_ff[0]) begin
               u_in = u_ff >> 1; v_in = v_ff >> 1; k_in = k_ff + CNT_W'(1);
            end else if (!u_ff[0]) begin
               u_in = u_ff >> 1;
            end else if (!v_ff[0]) begin
               v_in = v_ff >> 1;
            end else if (u_ff >= v_ff) begin
               u_in = u_ff - v_ff;
            end else begin
               v_in = v_ff - u_ff;
            end
         end
         U_DIVN: begin
            rem_in = rem_next; quo_in = quo_next; cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_last) begin
               nred_in = quo_next; quo_in = d_ff; rem_in = '0;
            end
         end
         U_DIVD: begin
            rem_in = rem_next; quo_in = quo_next; cnt_in = cnt_ff + CNT_W'(1);
         end
         U_DONE: ;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= U_IDLE;
      end else begin
         state_ff <= state_in;
      end
      u_ff <= u_in; v_ff <= v_in; k_ff <= k_in; cnt_ff <= cnt_in;
      d_ff <= d_in; g_ff <= g_in; rem_ff <= rem_in; quo_ff <= quo_in; nred_ff <= nred_in;
   end

   assign resp.done = state_ff == U_DONE;
   assign resp.nred = nred_ff;
   assign resp.dred = quo_ff;

endmodule
`default_nettype wire

>>> design/rational_arithmetic_unit.sv
`default_nettype none
// channel  | direction | tdata fields (low bit up)                       | tuser
// req      | in        | opcode, a_num, a_den, b_num, b_den (136 bits)   | none
// rsp      | out       | res_num, res_den, status (72 bits)              | none
//
// One word at a time. A word takes up to three products on one shared 32x32
// multiplier, a sum step, a binary gcd and two restoring divisions by the gcd,
// each giving 64 quotient bits. Error cases skip the rest of the work.
// req_tready is high only when idle.
// Reset is synchronous; a stalled rsp word is held until taken.
module rational_arithmetic_unit (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire [135:0] req_tdata,  // opcode[2:0], a_num, a_den, b_num, b_den
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [71:0] rsp_tdata   // res_num[31:0], res_den[62:32], status[64:63]
);
   import rau_pkg::*;

   rau_state_type state_ff, state_in;
   logic [2:0]       op_ff, op_in;
   logic             an_ff, ad_ff, bn_ff, bd_ff, an_in, ad_in, bn_in, bd_in;
   logic [WIDTH-1:0] am_ff, adm_ff, bm_ff, bdm_ff, am_in, adm_in, bm_in, bdm_in;
   logic [MAG_W-1:0] p_ff, q_ff, dm_ff, p_in, q_in, dm_in;
   logic             neg_ff, neg_in;
   logic [31:0]      fnum_ff, fnum_in;
   logic [30:0]      fden_ff, fden_in;
   logic [1:0]       fst_ff, fst_in;
   logic             rvalid_ff, rvalid_in;
   logic [31:0]      rnum_ff, rnum_in;
   logic [30:0]      rden_ff, rden_in;
   logic [1:0]       rst_ff, rst_in;

   logic             accept, is_norm, err, slot_free;
   logic [WIDTH-1:0] mul_a, mul_b, num_w;
   logic [MAG_W-1:0] prod, nmag;
   logic             nneg, dneg, pneg, qneg;
   logic [WIDTH-1:0] f_an, f_ad, f_bn, f_bd;
   rau_cmd_type      cmd;
   rau_resp_type     resp;

   assign req_tready = state_ff == S_IDLE;
   assign accept     = req_tvalid && req_tready;
   assign is_norm    = op_ff[2];
   assign slot_free  = !rvalid_ff || rsp_tready;
   assign prod       = MAG_W'(mul_a) * MAG_W'(mul_b);

   assign f_an = req_tdata[3 +: WIDTH];
   assign f_ad = req_tdata[35 +: WIDTH];
   assign f_bn = req_tdata[67 +: WIDTH];
   assign f_bd = req_tdata[99 +: WIDTH];

   // operand faults
   always_comb begin
      if (is_norm) begin
         err = adm_ff == '0;
      end else begin
         err = adm_ff == '0 || bdm_ff == '0 || (op_ff == OP_DIV && bm_ff == '0);
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:  if (accept) state_in = S_MUL0;
         S_MUL0: begin
            if (err) state_in = S_EMIT;
            else if (is_norm) state_in = S_SUM;
            else state_in = S_MUL1;
         end
         S_MUL1:  state_in = S_MUL2;
         S_MUL2:  state_in = S_SUM;
         S_SUM:   state_in = S_RED;
         S_RED:   if (resp.done) state_in = S_CHECK;
         S_CHECK: state_in = S_EMIT;
         S_EMIT:  if (slot_free) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // multiplier operand select
   always_comb begin
      mul_a = am_ff; mul_b = bdm_ff;
      unique case (state_ff)
         S_MUL0: if (op_ff == OP_MUL) mul_b = bm_ff;
         S_MUL1: begin mul_a = bm_ff; mul_b = adm_ff; end
         S_MUL2: begin mul_a = adm_ff; mul_b = (op_ff == OP_DIV) ? bm_ff : bdm_ff; end
         default: ;
      endcase
   end

   // numerator combine and signs
   always_comb begin
      pneg = an_ff ^ bd_ff;
      qneg = (bn_ff ^ ad_ff) ^ (op_ff == OP_SUB);
      nmag = p_ff; nneg = pneg; dneg = ad_ff ^ bd_ff;
      priority if (is_norm) begin
         nneg = an_ff; dneg = ad_ff;
      end else if (op_ff == OP_MUL) begin
         nneg = an_ff ^ bn_ff;
      end else if (op_ff == OP_DIV) begin
         dneg = ad_ff ^ bn_ff;
      end else if (pneg == qneg) begin
         nmag = p_ff + q_ff;
      end else if (p_ff >= q_ff) begin
         nmag = p_ff - q_ff;
      end else begin
         nneg = qneg; nmag = q_ff - p_ff;
      end
   end

   assign cmd.start = state_ff == S_SUM;
   assign cmd.nmag  = nmag;
   assign cmd.dmag  = dm_ff;
   assign num_w     = neg_ff ? -resp.nred[WIDTH-1:0] : resp.nred[WIDTH-1:0];

   // datapath and result
   always_comb begin
      op_in = op_ff; an_in = an_ff; ad_in = ad_ff; bn_in = bn_ff; bd_in = bd_ff;
      am_in = am_ff; adm_in = adm_ff; bm_in = bm_ff; bdm_in = bdm_ff;
      p_in = p_ff; q_in = q_ff; dm_in = dm_ff; neg_in = neg_ff;
      fnum_in = fnum_ff; fden_in = fden_ff; fst_in = fst_ff;
      rvalid_in = rvalid_ff && !rsp_tready;
      rnum_in = rnum_ff; rden_in = rden_ff; rst_in = rst_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in = req_tdata[2:0];
               an_in = f_an[WIDTH-1]; ad_in = f_ad[WIDTH-1];
               bn_in = f_bn[WIDTH-1]; bd_in = f_bd[WIDTH-1];
               am_in  = f_an[WIDTH-1] ? -f_an : f_an;
               adm_in = f_ad[WIDTH-1] ? -f_ad : f_ad;
               bm_in  = f_bn[WIDTH-1] ? -f_bn : f_bn;
               bdm_in = f_bd[WIDTH-1] ? -f_bd : f_bd;
            end
         end
         S_MUL0: begin
            p_in = prod;
            fnum_in = '0; fden_in = '0; fst_in = ST_ZERO_DEN;
            if (is_norm) begin
               p_in = MAG_W'(am_ff); dm_in = MAG_W'(adm_ff);
               if (err) begin
                  fden_in = 31'd1;
                  if (am_ff != '0) fnum_in = an_ff ? '1 : 32'd1;
               end
            end
         end
         S_MUL1: q_in = prod;
         S_MUL2: dm_in = prod;
         S_SUM:  neg_in = (nneg != dneg) && nmag != '0;
         S_CHECK: begin
            if (resp.dred > POS_LIMIT || resp.nred > (neg_ff ? NEG_LIMIT : POS_LIMIT)) begin
               fnum_in = '0; fden_in = '0; fst_in = ST_OVERFLOW;
            end else begin
               fnum_in = 32'($signed(num_w)); fden_in = 31'(resp.dred); fst_in = ST_OK;
            end
         end
         S_EMIT: begin
            if (slot_free) begin
               rvalid_in = 1'b1; rnum_in = fnum_ff; rden_in = fden_ff; rst_in = fst_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         rvalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         rvalid_ff <= rvalid_in;
      end
      op_ff <= op_in; an_ff <= an_in; ad_ff <= ad_in; bn_ff <= bn_in; bd_ff <= bd_in;
      am_ff <= am_in; adm_ff <= adm_in; bm_ff <= bm_in; bdm_ff <= bdm_in;
      p_ff <= p_in; q_ff <= q_in; dm_ff <= dm_in; neg_ff <= neg_in;
      fnum_ff <= fnum_in; fden_ff <= fden_in; fst_ff <= fst_in;
      rnum_ff <= rnum_in; rden_ff <= rden_in; rst_ff <= rst_in;
   end

   rau_reduce u_reduce (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .resp  (resp)
   );

   assign rsp_tvalid = rvalid_ff;
   assign rsp_tdata  = {7'b0, rst_ff, rden_ff, rnum_ff};

endmodule
`default_nettype wire

>>> design/rau_checker.sv
`default_nettype none
module rau_checker (
   input wire         clock,
   input wire         reset,
   input wire         req_tvalid,
   input wire         req_tready,
   input wire         rsp_tvalid,
   input wire         rsp_tready,
   input wire [71:0]  rsp_tdata
);
   import rau_pkg::*;

   // hold a stalled word
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp word changed under stall");

   // status is a known code
   a_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[64:63] != 2'd3)
      else $error("bad status code");

   // good result has a nonzero denominator
   a_den: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[64:63] == ST_OK |-> rsp_tdata[62:32] != '0)
      else $error("zero denominator with ok status");

   // overflow clears the fraction
   a_ovf: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[64:63] == ST_OVERFLOW |-> rsp_tdata[62:0] == '0)
      else $error("overflow word not cleared");

   // no intake right after a word is taken in
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("accepted two words back to back");

endmodule

bind rational_arithmetic_unit rau_checker u_rau_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
`default_nettype wire

>>> tb/sv/rational_arithmetic_unit_tb.sv
`default_nettype none
module rational_arithmetic_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import rau_pkg::*;

   localparam logic [2:0] OP_NORM = 3'd4;
   localparam int IDLE_LIMIT = 20000;

   // laid out as on rsp_tdata: status on top, numerator at the bottom
   typedef struct packed {
      logic [1:0]  status;
      logic [30:0] den;
      logic [31:0] num;
   } fraction_result_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [135:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [71:0]  rsp_tdata;

   fraction_result_type expected_results[$];
   int  mismatch_count = 0;
   int  idle_cycles = 0;
   int  hold_off_cycles = 0;
   bit  stall_enable = 1'b1;

   rational_arithmetic_unit dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   always #4 clock = ~clock;

   // Split a two's complement word into sign and magnitude
   function automatic void to_sign_mag(input logic [31:0] raw, output bit neg,
                                       output logic [63:0] mag);
      neg = raw[31];
      mag = {32'b0, (neg ? -raw : raw)};
   endfunction

   function automatic logic [63:0] gcd64(input logic [63:0] x, input logic [63:0] y);
      logic [63:0] t;
      while (x != 0) begin
         t = x;
         x = y % x;
         y = t;
      end
      return y;
   endfunction

   function automatic fraction_result_type make_result(input bit neg, input logic [63:0] nmag,
                                                       input logic [63:0] dmag,
                                                       input logic [1:0] st);
      fraction_result_type r;
      r.num = neg ? 32'(-nmag) : nmag[31:0];
      r.den = dmag[30:0];
      r.status = st;
      return r;
   endfunction

   // Compute the reduced fraction for one word
   function automatic fraction_result_type predict_fraction(input logic [2:0] op,
         input logic [31:0] an_raw, input logic [31:0] ad_raw,
         input logic [31:0] bn_raw, input logic [31:0] bd_raw);
      bit an, ad, bn, bd, nneg, dneg, neg, pneg, qneg;
      logic [63:0] am, adm, bm, bdm, nmag, dmag, g, p, q;
      to_sign_mag(an_raw, an, am);
      to_sign_mag(ad_raw, ad, adm);
      to_sign_mag(bn_raw, bn, bm);
      to_sign_mag(bd_raw, bd, bdm);
      if (op[2]) begin
         if (adm == 0)
            return make_result(an && am != 0, (am != 0) ? 64'd1 : 64'd0, 64'd1, ST_ZERO_DEN);
         nneg = an; nmag = am; dneg = ad; dmag = adm;
      end else begin
         if (adm == 0 || bdm == 0) return make_result(1'b0, 64'd0, 64'd0, ST_ZERO_DEN);
         if (op == OP_MUL) begin
            nneg = an ^ bn; nmag = am * bm;
            dneg = ad ^ bd; dmag = adm * bdm;
         end else if (op == OP_DIV) begin
            if (bm == 0) return make_result(1'b0, 64'd0, 64'd0, ST_ZERO_DEN);
            nneg = an ^ bd; nmag = am * bdm;
            dneg = ad ^ bn; dmag = adm * bm;
         end else begin
            pneg = an ^ bd; qneg = bn ^ ad;
            p = am * bdm; q = bm * adm;
            if (op == OP_SUB) qneg = !qneg;
            if (pneg == qneg) begin
               nneg = pneg; nmag = p + q;
            end else if (p >= q) begin
               nneg = pneg; nmag = p - q;
            end else begin
               nneg = qneg; nmag = q - p;
            end
            dneg = ad ^ bd; dmag = adm * bdm;
         end
      end
      neg = (nneg != dneg) && nmag != 0;
      g = gcd64(nmag, dmag);
      nmag = nmag / g;
      dmag = dmag / g;
      if (dmag > POS_LIMIT || nmag > (neg ? NEG_LIMIT : POS_LIMIT))
         return make_result(1'b0, 64'd0, 64'd0, ST_OVERFLOW);
      return make_result(neg, nmag, dmag, ST_OK);
   endfunction

   // Offer one word, record its expectation once accepted
   task automatic send_fraction_pair(input logic [2:0] op, input logic [31:0] an,
                                     input logic [31:0] ad, input logic [31:0] bn,
                                     input logic [31:0] bd);
      req_tdata = {5'b0, bd, bn, ad, an, op};
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      expected_results.push_back(predict_fraction(op, an, ad, bn, bd));
      @(negedge clock);
      req_tvalid = 1'b0;
   endtask

   task automatic wait_drained();
      while (expected_results.size() != 0) @(negedge clock);
   endtask

   function automatic logic [31:0] pick_operand();
      case ($urandom_range(0, 5))
         0: return 32'($urandom_range(0, 20)) * ($urandom_range(0, 1) ? -1 : 1);
         1: return {$urandom_range(0, 1) ? 16'hffff : 16'h0, 16'($urandom)};
         2: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
         3: return 32'(($urandom_range(1, 200)) * ($urandom_range(1, 60)));
         default: return $urandom;
      endcase
   endfunction

   task automatic test_directed();
      logic [2:0] op;
      for (int i = 0; i < 5; i++) begin
         op = 3'(i);
         send_fraction_pair(op, 32'd1, 32'd2, 32'd1, 32'd3);
         send_fraction_pair(op, 32'h8000_0000, 32'hffff_ffff, 32'h7fff_ffff, 32'h8000_0000);
      end
      // zero numerator, zero denominators, divide by zero fraction
      send_fraction_pair(OP_ADD, 32'd0, 32'd5, 32'd0, 32'hffff_fffd);
      send_fraction_pair(OP_MUL, 32'd3, 32'd0, 32'd1, 32'd2);
      send_fraction_pair(OP_SUB, 32'd3, 32'd4, 32'd1, 32'd0);
      send_fraction_pair(OP_DIV, 32'd3, 32'd4, 32'd0, 32'd7);
      // normalize with zero denominator for each numerator sign, then a negative denominator
      send_fraction_pair(OP_NORM, 32'hffff_fff9, 32'd0, 32'd0, 32'd0);
      send_fraction_pair(OP_NORM, 32'd9, 32'd0, 32'd0, 32'd0);
      send_fraction_pair(OP_NORM, 32'd0, 32'd0, 32'd0, 32'd0);
      send_fraction_pair(OP_NORM, 32'd6, 32'hffff_fff7, 32'd0, 32'd0);
      // opcodes above normalize act as normalize
      send_fraction_pair(3'd5, 32'd10, 32'd4, $urandom, $urandom);
      send_fraction_pair(3'd6, 32'h8000_0000, 32'hffff_ffff, $urandom, $urandom);
      send_fraction_pair(3'd7, 32'hffff_ffff, 32'h8000_0000, $urandom, $urandom);
      // overflow on sum and product
      send_fraction_pair(OP_ADD, 32'h7fff_ffff, 32'd1, 32'h7fff_ffff, 32'd1);
      send_fraction_pair(OP_MUL, 32'h10000, 32'd1, 32'h10000, 32'd1);
      wait_drained();
   endtask

   task automatic test_random(input int count);
      int burst;
      int sent = 0;
      while (sent < count) begin
         burst = $urandom_range(1, 12);
         for (int k = 0; k < burst && sent < count; k++) begin
            send_fraction_pair(3'($urandom), pick_operand(), pick_operand(),
                               pick_operand(), pick_operand());
            sent++;
         end
         if ($urandom_range(0, 2) != 0) repeat ($urandom_range(1, 40)) @(negedge clock);
      end
   endtask

   // Receiver holds off while the sender keeps offering, then random traffic with receiver always ready
   task automatic test_backpressure();
      hold_off_cycles = 3000;
      for (int k = 0; k < 6; k++)
         send_fraction_pair(3'($urandom_range(0, 4)), pick_operand(), pick_operand(),
                            pick_operand(), pick_operand());
      wait_drained();
      stall_enable = 1'b0;
      test_random(60);
      wait_drained();
      stall_enable = 1'b1;
   endtask

   // Stall the result side on its own pattern
   always @(negedge clock) begin
      if (hold_off_cycles > 0) begin
         hold_off_cycles = hold_off_cycles - 1;
         rsp_tready <= 1'b0;
      end else if (!stall_enable) begin
         rsp_tready <= 1'b1;
      end else begin
         rsp_tready <= ($urandom_range(0, 3) != 0);
      end
   end

   // Compare each accepted word with the oldest expectation
   always @(posedge clock) begin
      fraction_result_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[64:0];
         if (expected_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected result word %h", rsp_tdata);
         end else begin
            want = expected_results.pop_front();
            if (got.num !== want.num || got.den !== want.den || got.status !== want.status) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: num %h/%h den %h/%h status %0d/%0d (expected/actual)",
                           want.num, got.num, want.den, got.den, want.status, got.status);
            end
         end
      end
   end

   // Watchdog on cycles without any accepted word
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_backpressure();
      test_random(1320);
      wait_drained();
      repeat (400) @(negedge clock);
      if (mismatch_count == 0 && expected_results.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end
endmodule
`default_nettype wire

>>> sim.f
design/rau_pkg.sv
design/rau_reduce.sv
design/rational_arithmetic_unit.sv
design/rau_checker.sv
tb/sv/rational_arithmetic_unit_tb.sv
